[src/bilinear_quad_surface_map_assert.svh]
// Assertion macros used by the surface map checker.
`ifndef BILINEAR_QUAD_SURFACE_MAP_ASSERT_SVH
`define BILINEAR_QUAD_SURFACE_MAP_ASSERT_SVH

// checked outside reset only
`define BQSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define BQSM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/bqsm_pkg.sv]
`default_nettype none

package bqsm_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int ONE        = 1 << FRAC_BITS;

  localparam int REF_W    = 16;
  localparam int OUT_W    = 16;
  localparam int AREA_W   = 36;
  localparam int SLOT_W   = 16;
  localparam int NUM_AXES = 3;
  localparam int NUM_VTX  = 4;
  localparam int VTX_W    = NUM_AXES * SLOT_W;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX3 = 3'd3;

  localparam int CLAMP_W = REF_W + 2;
  localparam int AB_W    = FRAC_BITS + 1;
  localparam int W_W     = 2 * FRAC_BITS + 1;
  localparam int D_W     = COORD_BITS + 1;
  localparam int TR_W    = D_W + AB_W + 1;
  localparam int T_W     = COORD_BITS + 2;
  localparam int P_W     = W_W + COORD_BITS + 2;
  localparam int CR_W    = 2 * T_W + 1;
  localparam int MAG_W   = 2 * T_W;
  localparam int HALF_W  = T_W;
  localparam int PP_W    = 2 * HALF_W;
  localparam int G_W     = 2 * MAG_W;
  localparam int ROOT_W  = MAG_W;
  localparam int SIDE_W  = NUM_AXES * OUT_W;

endpackage

`default_nettype wire

[src/bqsm_isqrt.sv]
`default_nettype none

module bqsm_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [bqsm_pkg::G_W-1:0]       radicand_i,
  input  logic [bqsm_pkg::SIDE_W-1:0]    side_i,
  output logic                           valid_o,
  output logic [bqsm_pkg::ROOT_W-1:0]    root_o,
  output logic [bqsm_pkg::SIDE_W-1:0]    side_o
);

  localparam int STEPS = bqsm_pkg::ROOT_W;
  localparam int REM_W = bqsm_pkg::ROOT_W + 1;
  localparam int TRY_W = REM_W + 2;

  logic                        v_q    [STEPS];
  logic [REM_W-1:0]            rem_q  [STEPS];
  logic [bqsm_pkg::ROOT_W-1:0] root_q [STEPS];
  logic [bqsm_pkg::G_W-1:0]    rad_q  [STEPS];
  logic [bqsm_pkg::SIDE_W-1:0] side_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic                        v_in;
    logic [REM_W-1:0]            rem_in;
    logic [bqsm_pkg::ROOT_W-1:0] root_in;
    logic [bqsm_pkg::G_W-1:0]    rad_in;
    logic [bqsm_pkg::SIDE_W-1:0] side_in;
    logic [TRY_W-1:0]            rem2;
    logic [TRY_W-1:0]            trial;
    logic [REM_W-1:0]            rem_d;
    logic [bqsm_pkg::ROOT_W-1:0] root_d;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign side_in = side_q[s-1];
    end

    // one root bit per stage: bring down two radicand bits, try 4r+1
    always_comb begin
      rem2  = {rem_in, rad_in[bqsm_pkg::G_W-1 -: 2]};
      trial = TRY_W'({root_in, 2'b01});
      if (rem2 >= trial) begin
        rem_d  = REM_W'(rem2 - trial);
        root_d = {root_in[bqsm_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(rem2);
        root_d = {root_in[bqsm_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        rad_q[s]  <= rad_in << 2;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign root_o  = root_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

`default_nettype wire

[src/bilinear_quad_surface_map.sv]
// Throughput: one word per cycle unless the output skid entry is full; six arithmetic stages
// feed a 36-stage square root pipeline that retires one root bit per stage.
// A two-entry output (register plus skid) stalls the whole pipeline only when both are full.
// Reset (async, active low) clears all valid bits and the four vertex registers to zero.
`default_nettype none

module bilinear_quad_surface_map (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bqsm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bqsm_pkg::VTX_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [bqsm_pkg::REF_W-1:0]    ref_u_i,
  input  logic signed [bqsm_pkg::REF_W-1:0]    ref_v_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bqsm_pkg::OUT_W-1:0]    global_x_o,
  output logic signed [bqsm_pkg::OUT_W-1:0]    global_y_o,
  output logic signed [bqsm_pkg::OUT_W-1:0]    global_z_o,
  output logic [bqsm_pkg::AREA_W-1:0]          area_factor_o
);

  localparam int NUM_ST = 6;
  localparam int NV     = bqsm_pkg::NUM_VTX;
  localparam int NA     = bqsm_pkg::NUM_AXES;
  localparam int OW     = bqsm_pkg::OUT_W;

  localparam logic signed [bqsm_pkg::CLAMP_W-1:0] ONE_C  = bqsm_pkg::CLAMP_W'(bqsm_pkg::ONE);
  localparam logic [bqsm_pkg::AB_W-1:0]           ONE_AB = bqsm_pkg::AB_W'(bqsm_pkg::ONE);

  typedef struct packed {
    logic signed [OW-1:0]              x;
    logic signed [OW-1:0]              y;
    logic signed [OW-1:0]              z;
    logic [bqsm_pkg::AREA_W-1:0]       area;
  } res_t;

  // vertex registers
  logic [bqsm_pkg::VTX_W-1:0] vtx_q [NV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) vtx_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bqsm_pkg::REG_VERTEX0: vtx_q[0] <= cfg_data_i;
        bqsm_pkg::REG_VERTEX1: vtx_q[1] <= cfg_data_i;
        bqsm_pkg::REG_VERTEX2: vtx_q[2] <= cfg_data_i;
        bqsm_pkg::REG_VERTEX3: vtx_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [bqsm_pkg::COORD_BITS-1:0] g   [NV][NA];
  logic signed [bqsm_pkg::D_W-1:0]        d10 [NA];
  logic signed [bqsm_pkg::D_W-1:0]        d23 [NA];
  logic signed [bqsm_pkg::D_W-1:0]        d30 [NA];
  logic signed [bqsm_pkg::D_W-1:0]        d21 [NA];

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      for (int k = 0; k < NA; k++) begin
        g[i][k] = vtx_q[i][bqsm_pkg::SLOT_W*k +: bqsm_pkg::COORD_BITS];
      end
    end
    for (int k = 0; k < NA; k++) begin
      d10[k] = bqsm_pkg::D_W'(g[1][k]) - bqsm_pkg::D_W'(g[0][k]);
      d23[k] = bqsm_pkg::D_W'(g[2][k]) - bqsm_pkg::D_W'(g[3][k]);
      d30[k] = bqsm_pkg::D_W'(g[3][k]) - bqsm_pkg::D_W'(g[0][k]);
      d21[k] = bqsm_pkg::D_W'(g[2][k]) - bqsm_pkg::D_W'(g[1][k]);
    end
  end

  // pipeline control
  logic [NUM_ST-1:0] v_q;
  logic              skid_v_q;
  logic              out_v_q;
  logic              adv;

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NUM_ST-2:0], in_valid_i};
    end
  end

  // stage 1: clamp, alpha and beta
  logic signed [bqsm_pkg::CLAMP_W-1:0] u_ext, v_ext, u_cl, v_cl, u_sum, v_sum;
  logic [bqsm_pkg::AB_W-1:0]           a_d, b_d;
  logic [bqsm_pkg::AB_W-1:0]           a_q, b_q, oma_q, omb_q;

  always_comb begin
    u_ext = bqsm_pkg::CLAMP_W'(ref_u_i);
    v_ext = bqsm_pkg::CLAMP_W'(ref_v_i);
    u_cl  = (u_ext > ONE_C) ? ONE_C : ((u_ext < -ONE_C) ? -ONE_C : u_ext);
    v_cl  = (v_ext > ONE_C) ? ONE_C : ((v_ext < -ONE_C) ? -ONE_C : v_ext);
    u_sum = u_cl + ONE_C;
    v_sum = v_cl + ONE_C;
    a_d   = u_sum[bqsm_pkg::AB_W:1];
    b_d   = v_sum[bqsm_pkg::AB_W:1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q   <= a_d;
      b_q   <= b_d;
      oma_q <= ONE_AB - a_d;
      omb_q <= ONE_AB - b_d;
    end
  end

  // stage 2: blend weights and floored tangents
  logic [bqsm_pkg::W_W-1:0]          w_d  [NV];
  logic [bqsm_pkg::W_W-1:0]          w_q  [NV];
  logic signed [bqsm_pkg::AB_W:0]    a_s, b_s, oma_s, omb_s;
  logic signed [bqsm_pkg::TR_W-1:0]  tr1  [NA];
  logic signed [bqsm_pkg::TR_W-1:0]  tr2  [NA];
  logic signed [bqsm_pkg::T_W-1:0]   t1_q [NA];
  logic signed [bqsm_pkg::T_W-1:0]   t2_q [NA];

  always_comb begin
    a_s   = {1'b0, a_q};
    b_s   = {1'b0, b_q};
    oma_s = {1'b0, oma_q};
    omb_s = {1'b0, omb_q};
    w_d[0] = bqsm_pkg::W_W'(oma_q) * bqsm_pkg::W_W'(omb_q);
    w_d[1] = bqsm_pkg::W_W'(a_q)   * bqsm_pkg::W_W'(omb_q);
    w_d[2] = bqsm_pkg::W_W'(a_q)   * bqsm_pkg::W_W'(b_q);
    w_d[3] = bqsm_pkg::W_W'(oma_q) * bqsm_pkg::W_W'(b_q);
    for (int k = 0; k < NA; k++) begin
      tr1[k] = bqsm_pkg::TR_W'(omb_s) * bqsm_pkg::TR_W'(d10[k])
             + bqsm_pkg::TR_W'(b_s)   * bqsm_pkg::TR_W'(d23[k]);
      tr2[k] = bqsm_pkg::TR_W'(oma_s) * bqsm_pkg::TR_W'(d30[k])
             + bqsm_pkg::TR_W'(a_s)   * bqsm_pkg::TR_W'(d21[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NV; i++) w_q[i] <= w_d[i];
      for (int k = 0; k < NA; k++) begin
        t1_q[k] <= bqsm_pkg::T_W'(tr1[k] >>> bqsm_pkg::FRAC_BITS);
        t2_q[k] <= bqsm_pkg::T_W'(tr2[k] >>> bqsm_pkg::FRAC_BITS);
      end
    end
  end

  // stage 3: blended point and cross product
  logic signed [bqsm_pkg::P_W-1:0]  p    [NA];
  logic signed [bqsm_pkg::CR_W-1:0] cr_d [NA];
  logic signed [bqsm_pkg::CR_W-1:0] cr_q [NA];
  logic [bqsm_pkg::SIDE_W-1:0]      pt_d;
  logic [bqsm_pkg::SIDE_W-1:0]      pt3_q, pt4_q, pt5_q, pt6_q;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      p[k] = '0;
      for (int i = 0; i < NV; i++) begin
        p[k] = p[k] + bqsm_pkg::P_W'(signed'({1'b0, w_q[i]})) * bqsm_pkg::P_W'(g[i][k]);
      end
      pt_d[OW*k +: OW] = OW'(p[k] >>> (2 * bqsm_pkg::FRAC_BITS));
    end
    cr_d[0] = bqsm_pkg::CR_W'(t1_q[1]) * bqsm_pkg::CR_W'(t2_q[2])
            - bqsm_pkg::CR_W'(t1_q[2]) * bqsm_pkg::CR_W'(t2_q[1]);
    cr_d[1] = bqsm_pkg::CR_W'(t1_q[2]) * bqsm_pkg::CR_W'(t2_q[0])
            - bqsm_pkg::CR_W'(t1_q[0]) * bqsm_pkg::CR_W'(t2_q[2]);
    cr_d[2] = bqsm_pkg::CR_W'(t1_q[0]) * bqsm_pkg::CR_W'(t2_q[1])
            - bqsm_pkg::CR_W'(t1_q[1]) * bqsm_pkg::CR_W'(t2_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt3_q <= pt_d;
      for (int k = 0; k < NA; k++) cr_q[k] <= cr_d[k];
    end
  end

  // stage 4: split squares into 18x18 partial products
  logic [bqsm_pkg::MAG_W-1:0]  mag  [NA];
  logic [bqsm_pkg::HALF_W-1:0] hi   [NA];
  logic [bqsm_pkg::HALF_W-1:0] lo   [NA];
  logic [bqsm_pkg::PP_W-1:0]   hh_q [NA];
  logic [bqsm_pkg::PP_W-1:0]   hl_q [NA];
  logic [bqsm_pkg::PP_W-1:0]   ll_q [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      mag[k] = cr_q[k][bqsm_pkg::CR_W-1] ? bqsm_pkg::MAG_W'(-cr_q[k])
                                         : bqsm_pkg::MAG_W'(cr_q[k]);
      hi[k]  = mag[k][bqsm_pkg::MAG_W-1:bqsm_pkg::HALF_W];
      lo[k]  = mag[k][bqsm_pkg::HALF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt4_q <= pt3_q;
      for (int k = 0; k < NA; k++) begin
        hh_q[k] <= bqsm_pkg::PP_W'(hi[k]) * bqsm_pkg::PP_W'(hi[k]);
        hl_q[k] <= bqsm_pkg::PP_W'(hi[k]) * bqsm_pkg::PP_W'(lo[k]);
        ll_q[k] <= bqsm_pkg::PP_W'(lo[k]) * bqsm_pkg::PP_W'(lo[k]);
      end
    end
  end

  // stage 5: squares; stage 6: Gram determinant
  logic [bqsm_pkg::G_W-1:0] sq_q [NA];
  logic [bqsm_pkg::G_W-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt5_q <= pt4_q;
      for (int k = 0; k < NA; k++) begin
        sq_q[k] <= (bqsm_pkg::G_W'(hh_q[k]) << (2 * bqsm_pkg::HALF_W))
                 + (bqsm_pkg::G_W'(hl_q[k]) << (bqsm_pkg::HALF_W + 1))
                 + bqsm_pkg::G_W'(ll_q[k]);
      end
      pt6_q <= pt5_q;
      rad_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // square root
  logic                          sq_valid;
  logic [bqsm_pkg::ROOT_W-1:0]   sq_root;
  logic [bqsm_pkg::SIDE_W-1:0]   sq_side;

  bqsm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (v_q[NUM_ST-1]),
    .radicand_i (rad_q),
    .side_i     (pt6_q),
    .valid_o    (sq_valid),
    .root_o     (sq_root),
    .side_o     (sq_side)
  );

  // output register with skid
  res_t res_new, out_q, skid_q;
  logic take_out, arrive;

  always_comb begin
    res_new.x    = sq_side[0 +: OW];
    res_new.y    = sq_side[OW +: OW];
    res_new.z    = sq_side[2*OW +: OW];
    res_new.area = bqsm_pkg::AREA_W'(sq_root);
  end

  assign take_out = !out_v_q || !out_stall_i;
  assign arrive   = adv && sq_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take_out) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= arrive;
      end
    end else if (arrive) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_out) begin
      out_q <= skid_v_q ? skid_q : res_new;
    end else if (arrive) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o   = out_v_q;
  assign global_x_o    = out_q.x;
  assign global_y_o    = out_q.y;
  assign global_z_o    = out_q.z;
  assign area_factor_o = out_q.area;

endmodule

`default_nettype wire

[src/bqsm_checker.sv]
`default_nettype none

`include "bilinear_quad_surface_map_assert.svh"

module bqsm_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_stall_o,
  input  logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  logic signed [bqsm_pkg::OUT_W-1:0]    global_x_o,
  input  logic signed [bqsm_pkg::OUT_W-1:0]    global_y_o,
  input  logic signed [bqsm_pkg::OUT_W-1:0]    global_z_o,
  input  logic [bqsm_pkg::AREA_W-1:0]          area_factor_o
);

  // input side only backs up behind a held result
  `BQSM_ASSERT_ALWAYS(a_stall_needs_result, in_stall_o |-> out_valid_o, "input stalled without a pending result")

  // a taken result frees the skid entry at once
  `BQSM_ASSERT(a_stall_clears, in_stall_o && !out_stall_i |=> !in_stall_o, "input stall outlived a drained output")

  `BQSM_ASSERT(a_stall_cause, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i), "input stall without a stalled output word")

  `BQSM_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(global_x_o) && $stable(global_y_o) && $stable(global_z_o) && $stable(area_factor_o), "stalled output word changed")

endmodule

bind bilinear_quad_surface_map bqsm_checker u_bqsm_checker (.*);

`default_nettype wire
